// ===== sv/two_tier_buffer_tracker_fifo_evict_core_defines.svh =====
// assertion macros for the buffer tracker checker
`ifndef TWO_TIER_BUFFER_TRACKER_FIFO_EVICT_CORE_DEFINES_SVH
`define TWO_TIER_BUFFER_TRACKER_FIFO_EVICT_CORE_DEFINES_SVH

// clocked assertion, off while reset is held
`define TTB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define TTB_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== sv/ttb_pkg.sv =====
// shared types and constants of the two-tier buffer tracker
package ttb_pkg;

    localparam int OC_AW    = 6;
    localparam int HB_AW    = 10;
    localparam int OC_DEPTH = 1 << OC_AW;
    localparam int HB_DEPTH = 1 << HB_AW;
    localparam int OC_CW    = OC_AW + 1;
    localparam int HB_CW    = HB_AW + 1;
    localparam int PADDR_W  = 3;

    localparam logic [2:0] MODE_INSERT = 3'd0;
    localparam logic [2:0] MODE_EVICT  = 3'd1;
    localparam logic [2:0] MODE_TAKE   = 3'd2;
    localparam logic [2:0] MODE_CLEAN  = 3'd3;
    localparam logic [2:0] MODE_PIN    = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_NOEVICT  = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    localparam logic REG_ONCHIP_LIMIT = 1'b0;
    localparam logic REG_HBM_LIMIT    = 1'b1;

    localparam logic [OC_CW-1:0] OC_LIMIT_RST = OC_CW'(OC_DEPTH);
    localparam logic [HB_CW-1:0] HB_LIMIT_RST = HB_CW'(HB_DEPTH);

    typedef struct packed {
        logic [2:0]  mode;
        logic        tier;
        logic [63:0] origin_addr;
        logic [63:0] shadow_addr;
        logic        pin;
    } t_cmd;

    typedef struct packed {
        logic [1:0]       status;
        logic             hit_tier;
        logic [63:0]      origin_out;
        logic [63:0]      shadow_out;
        logic [OC_CW-1:0] onchip_count;
        logic [HB_CW-1:0] hbm_count;
        logic             onchip_full;
        logic             hbm_full;
    } t_res;

    typedef struct packed {
        logic [63:0] origin;
        logic [63:0] shadow;
        logic        pin;
    } t_oc_word;

    typedef struct packed {
        logic [63:0] origin;
        logic [63:0] shadow;
    } t_hb_word;

endpackage

// ===== sv/ttb_ram.sv =====
// simple dual-port ram with registered read data
module ttb_ram #(
    parameter int AW = 6,
    parameter int DW = 128
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] mem [2**AW];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

// ===== sv/two_tier_buffer_tracker_fifo_evict_core.sv =====
// two-tier buffer tracker: oldest-first eviction with pinned on-chip entries
//
// One command is taken when start is high and busy is low; its single result
// appears on o_res for one cycle with o_done, and cannot be held off. Each
// tier is a circular buffer in its own ram, oldest entry at the head pointer,
// and every step reads that ram and then checks the word or writes it back.
// A command searches its tier entry by entry (insert, take, clean, set pin),
// shifts each entry behind a removed one down by one place, and on an on-chip
// evict rotates each pinned entry to the newest end; a clean that misses the
// on-chip tier goes on to search the hbm tier.
module two_tier_buffer_tracker_fifo_evict_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  ttb_pkg::t_cmd          i_cmd,
    output logic                   o_done,
    output ttb_pkg::t_res          o_res,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [ttb_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);
    import ttb_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_SRCH_RD, S_SRCH_CHK, S_SHIFT_RD, S_SHIFT_WR,
        S_APPEND, S_EVICT_RD, S_EVICT_CHK, S_DONE
    } t_state;

    t_state           r_state;
    logic [2:0]       r_mode;
    logic             r_tier;
    logic [63:0]      r_org;
    logic [63:0]      r_key;
    logic             r_pin;
    logic [HB_CW-1:0] r_pos;
    logic [1:0]       r_status;
    logic [63:0]      r_org_o;
    logic [63:0]      r_sh_o;
    logic [OC_CW-1:0] r_oc_cnt;
    logic [HB_CW-1:0] r_hb_cnt;
    logic [OC_AW-1:0] r_oc_head;
    logic [HB_AW-1:0] r_hb_head;
    logic [OC_CW-1:0] r_oc_limit;
    logic [HB_CW-1:0] r_hb_limit;
    logic             r_done;
    t_res             r_res;

    t_oc_word         oc_rdata, oc_wdata;
    t_hb_word         hb_rdata, hb_wdata;
    logic [OC_AW-1:0] oc_raddr, oc_waddr;
    logic [HB_AW-1:0] hb_raddr, hb_waddr;
    logic             oc_we, hb_we, wr_en;
    logic [HB_CW-1:0] cur_cnt, rd_pos, wr_pos;
    logic             cur_full;
    logic [63:0]      rd_origin, rd_shadow;
    logic             rd_pin, found;
    logic             cfg_wr;

    // current tier view
    always_comb begin
        cur_cnt   = r_tier ? r_hb_cnt : HB_CW'(r_oc_cnt);
        cur_full  = r_tier ? (r_hb_cnt == HB_CW'(HB_DEPTH)) : (r_oc_cnt == OC_CW'(OC_DEPTH));
        rd_origin = r_tier ? hb_rdata.origin : oc_rdata.origin;
        rd_shadow = r_tier ? hb_rdata.shadow : oc_rdata.shadow;
        rd_pin    = r_tier ? 1'b0 : oc_rdata.pin;
        found     = (rd_shadow == r_key);
    end

    // ram access for the current state
    always_comb begin
        case (r_state)
            S_SHIFT_RD: rd_pos = r_pos + HB_CW'(1);
            S_EVICT_RD: rd_pos = '0;
            default:    rd_pos = r_pos;
        endcase
        wr_pos = ((r_state == S_APPEND) || (r_state == S_EVICT_CHK)) ? cur_cnt : r_pos;
        wr_en  = (r_state == S_SHIFT_WR)
              || ((r_state == S_APPEND) && !cur_full)
              || ((r_state == S_EVICT_CHK) && rd_pin)
              || ((r_state == S_SRCH_CHK) && found && (r_mode == MODE_PIN));
        oc_we  = wr_en && !r_tier;
        hb_we  = wr_en && r_tier;
        oc_raddr = r_oc_head + rd_pos[OC_AW-1:0];
        hb_raddr = r_hb_head + rd_pos[HB_AW-1:0];
        oc_waddr = r_oc_head + wr_pos[OC_AW-1:0];
        hb_waddr = r_hb_head + wr_pos[HB_AW-1:0];
        if (r_state == S_APPEND) begin
            oc_wdata = '{origin: r_org, shadow: r_key, pin: r_pin};
        end else if (r_state == S_SRCH_CHK) begin
            oc_wdata = '{origin: rd_origin, shadow: rd_shadow, pin: r_pin};
        end else begin
            oc_wdata = oc_rdata;
        end
        hb_wdata = (r_state == S_APPEND) ? '{origin: r_org, shadow: r_key} : hb_rdata;
    end

    ttb_ram #(.AW(OC_AW), .DW($bits(t_oc_word))) u_oc_ram (
        .i_clk   (i_clk),
        .i_we    (oc_we),
        .i_waddr (oc_waddr),
        .i_wdata (oc_wdata),
        .i_raddr (oc_raddr),
        .o_rdata (oc_rdata)
    );

    ttb_ram #(.AW(HB_AW), .DW($bits(t_hb_word))) u_hb_ram (
        .i_clk   (i_clk),
        .i_we    (hb_we),
        .i_waddr (hb_waddr),
        .i_wdata (hb_wdata),
        .i_raddr (hb_raddr),
        .o_rdata (hb_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_oc_cnt  <= '0;
            r_hb_cnt  <= '0;
            r_oc_head <= '0;
            r_hb_head <= '0;
            r_done    <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_mode   <= i_cmd.mode;
                        r_org    <= i_cmd.origin_addr;
                        r_key    <= i_cmd.shadow_addr;
                        r_pin    <= i_cmd.pin;
                        r_pos    <= '0;
                        r_status <= ST_OK;
                        r_org_o  <= '0;
                        r_sh_o   <= '0;
                        r_tier   <= ((i_cmd.mode == MODE_INSERT) || (i_cmd.mode == MODE_EVICT)
                                     || (i_cmd.mode == MODE_TAKE)) ? i_cmd.tier : 1'b0;
                        case (i_cmd.mode)
                            MODE_INSERT: begin
                                if (i_cmd.shadow_addr == '0) begin
                                    r_status <= ST_NOTFOUND;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_state <= S_SRCH_RD;
                                end
                            end
                            MODE_EVICT: r_state <= S_EVICT_RD;
                            MODE_TAKE:  r_state <= S_SRCH_RD;
                            MODE_CLEAN: r_state <= S_SRCH_RD;
                            MODE_PIN:   r_state <= S_SRCH_RD;
                            default:    r_state <= S_DONE;
                        endcase
                    end
                end
                S_SRCH_RD: begin
                    if (r_pos == cur_cnt) begin
                        // key missing from this tier
                        if (r_mode == MODE_INSERT) begin
                            r_state <= S_APPEND;
                        end else if ((r_mode == MODE_CLEAN) && !r_tier) begin
                            r_tier <= 1'b1;
                            r_pos  <= '0;
                        end else begin
                            if (r_mode == MODE_CLEAN) begin
                                r_tier <= 1'b0;
                            end
                            r_status <= ST_NOTFOUND;
                            r_state  <= S_DONE;
                        end
                    end else begin
                        r_state <= S_SRCH_CHK;
                    end
                end
                S_SRCH_CHK: begin
                    if (found) begin
                        if ((r_mode == MODE_TAKE) || (r_mode == MODE_CLEAN)) begin
                            r_org_o <= rd_origin;
                            r_sh_o  <= rd_shadow;
                        end
                        r_state <= (r_mode == MODE_PIN) ? S_DONE : S_SHIFT_RD;
                    end else begin
                        r_pos   <= r_pos + HB_CW'(1);
                        r_state <= S_SRCH_RD;
                    end
                end
                S_SHIFT_RD: begin
                    if ((r_pos + HB_CW'(1)) >= cur_cnt) begin
                        if (r_tier) begin
                            r_hb_cnt <= r_hb_cnt - HB_CW'(1);
                        end else begin
                            r_oc_cnt <= r_oc_cnt - OC_CW'(1);
                        end
                        r_state <= (r_mode == MODE_INSERT) ? S_APPEND : S_DONE;
                    end else begin
                        r_state <= S_SHIFT_WR;
                    end
                end
                S_SHIFT_WR: begin
                    r_pos   <= r_pos + HB_CW'(1);
                    r_state <= S_SHIFT_RD;
                end
                S_APPEND: begin
                    if (cur_full) begin
                        r_status <= ST_FULL;
                    end else if (r_tier) begin
                        r_hb_cnt <= r_hb_cnt + HB_CW'(1);
                    end else begin
                        r_oc_cnt <= r_oc_cnt + OC_CW'(1);
                    end
                    r_state <= S_DONE;
                end
                S_EVICT_RD: begin
                    // every entry rotated once means all are pinned
                    if (r_pos == cur_cnt) begin
                        r_status <= ST_NOEVICT;
                        r_state  <= S_DONE;
                    end else begin
                        r_state <= S_EVICT_CHK;
                    end
                end
                S_EVICT_CHK: begin
                    if (r_tier) begin
                        r_hb_head <= r_hb_head + HB_AW'(1);
                    end else begin
                        r_oc_head <= r_oc_head + OC_AW'(1);
                    end
                    if (rd_pin) begin
                        r_pos   <= r_pos + HB_CW'(1);
                        r_state <= S_EVICT_RD;
                    end else begin
                        r_org_o <= rd_origin;
                        r_sh_o  <= rd_shadow;
                        if (r_tier) begin
                            r_hb_cnt <= r_hb_cnt - HB_CW'(1);
                        end else begin
                            r_oc_cnt <= r_oc_cnt - OC_CW'(1);
                        end
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    r_done  <= 1'b1;
                    r_res   <= '{status:       r_status,
                                 hit_tier:     r_tier,
                                 origin_out:   r_org_o,
                                 shadow_out:   r_sh_o,
                                 onchip_count: r_oc_cnt,
                                 hbm_count:    r_hb_cnt,
                                 onchip_full:  (r_oc_cnt >= r_oc_limit),
                                 hbm_full:     (r_hb_cnt >= r_hb_limit)};
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // configuration port
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oc_limit <= OC_LIMIT_RST;
            r_hb_limit <= HB_LIMIT_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_HBM_LIMIT) begin
                r_hb_limit <= pwdata[HB_CW-1:0];
            end else begin
                r_oc_limit <= pwdata[OC_CW-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_ONCHIP_LIMIT) begin
            prdata = 32'(r_oc_limit);
        end else begin
            prdata = 32'(r_hb_limit);
        end
    end

    assign pready = 1'b1;
    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_res  = r_res;
endmodule

// ===== sv/ttb_checker.sv =====
// port-level checker for the buffer tracker, bound to the top level
`include "two_tier_buffer_tracker_fifo_evict_core_defines.svh"

module ttb_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input logic          o_done,
    input ttb_pkg::t_res o_res
);
    import ttb_pkg::*;

    `TTB_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted transaction did not raise busy")
    `TTB_ASSERT(a_done_idle, o_done |-> !busy, "result shown while still busy")
    `TTB_ASSERT(a_done_pulse, o_done |=> !o_done, "result strobe longer than one cycle")
    `TTB_ASSERT_ALWAYS(a_count_range, o_done |-> ((o_res.onchip_count <= OC_CW'(OC_DEPTH)) && (o_res.hbm_count <= HB_CW'(HB_DEPTH))), "tier count beyond depth")
endmodule

bind two_tier_buffer_tracker_fifo_evict_core ttb_checker u_ttb_checker (.*);
